@@ hdl/hpst_pkg.sv @@
`timescale 1ns / 1ps
// Package for the hashed pair set table.
// Holds the default sizes, field widths, mode codes and the controller state type.
package hpst_pkg;

  localparam int BUCKET_COUNT = 128;
  localparam int WAYS         = 4;
  localparam int KEY_W        = 32;
  localparam int TAG_W        = 32;
  localparam int PAIR_W       = KEY_W + TAG_W;

  localparam logic MODE_LOOKUP = 1'b0;
  localparam logic MODE_INSERT = 1'b1;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_HASH,
    ST_EXEC
  } hpst_state_t;

endpackage

@@ hdl/hpst_ram.sv @@
`timescale 1ns / 1ps
// Generic single-port-write, single-port-read synchronous RAM with registered read.
// Depends on nothing.
module hpst_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ hdl/hpst_hash.sv @@
`timescale 1ns / 1ps
// Three-stage integer hash of the key followed by the reduction to a bucket index.
// Depends on hpst_pkg for the key width.
module hpst_hash #(
  parameter int BUCKET_COUNT = hpst_pkg::BUCKET_COUNT
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            start,
  input  logic [hpst_pkg::KEY_W-1:0]      key,
  output logic                            done,
  output logic [$clog2(BUCKET_COUNT)-1:0] bucket
);

  localparam int  IDX_W   = $clog2(BUCKET_COUNT);
  localparam int  KW      = hpst_pkg::KEY_W;
  localparam bit  IS_POW2 = (BUCKET_COUNT & (BUCKET_COUNT - 1)) == 0;

  logic [KW-1:0] h1;
  logic [KW-1:0] h2;
  logic [KW-1:0] h3;
  logic [KW-1:0] s1;
  logic [KW-1:0] s2;
  logic [KW-1:0] s3;
  logic [KW-1:0] t1;
  logic [KW-1:0] t2;
  logic [KW-1:0] t3;
  logic          v1;
  logic          v2;
  logic          v3;

  always_comb begin
    t1 = key + ~(key << 15);
    s1 = t1 ^ (t1 >> 10);
    t2 = h1 + (h1 << 3);
    s2 = t2 ^ (t2 >> 6);
    t3 = h2 + ~(h2 << 11);
    s3 = t3 ^ (t3 >> 16);
  end

  always_ff @(posedge clk) begin
    h1 <= s1;
    h2 <= s2;
    h3 <= s3;
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
    end else begin
      v1 <= start;
      v2 <= v1;
      v3 <= v2;
    end
  end

  generate
    if (IS_POW2) begin : g_mask
      assign done   = v3;
      assign bucket = h3[IDX_W-1:0];
    end else begin : g_rem
      // The quotient estimate from the reciprocal is low by at most one, so a single
      // compare and subtract on the low bits yields the exact remainder.
      localparam int              RW     = IDX_W + 1;
      localparam logic [KW-1:0]   RECIP  = KW'((64'd1 << KW) / 64'(BUCKET_COUNT));
      localparam logic [RW-1:0]   BC_EXT = RW'(BUCKET_COUNT);

      logic [2*KW-1:0]  prod;
      logic [RW-1:0]    q_low;
      logic [RW-1:0]    h_low;
      logic [RW-1:0]    rem_raw;
      logic [IDX_W-1:0] rem;
      logic             v4;
      logic             v5;

      always_comb begin
        prod    = (2*KW)'(h3) * (2*KW)'(RECIP);
        rem_raw = h_low - RW'(q_low * BC_EXT);
      end

      always_ff @(posedge clk) begin
        q_low <= prod[KW +: RW];
        h_low <= h3[RW-1:0];
        if (rem_raw >= BC_EXT) begin
          rem <= IDX_W'(rem_raw - BC_EXT);
        end else begin
          rem <= rem_raw[IDX_W-1:0];
        end
        if (rst) begin
          v4 <= 1'b0;
          v5 <= 1'b0;
        end else begin
          v4 <= v3;
          v5 <= v4;
        end
      end

      assign done   = v5;
      assign bucket = rem;
    end
  endgenerate

endmodule

@@ hdl/hashed_pair_set_table.sv @@
`timescale 1ns / 1ps
// Hashed pair set table: lookup or insert of (key, tag) pairs in fixed-way buckets.
// The path from accepted start to the done strobe passes the three hash stages and the
// bucket row read when BUCKET_COUNT is a power of two; otherwise the bucket index also
// takes a reciprocal multiply stage and a correction stage.
// One item at a time: the next start is accepted in the cycle that done is high.
// After reset a clearing pass zeroes the fill counts of all buckets with busy high.
// The receiver cannot stall: done, found and overflow are valid for one cycle.
module hashed_pair_set_table #(
  parameter int BUCKET_COUNT = hpst_pkg::BUCKET_COUNT,
  parameter int WAYS         = hpst_pkg::WAYS
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  output logic                          busy,
  input  logic                          mode,
  input  logic [hpst_pkg::KEY_W-1:0]    key_id,
  input  logic [hpst_pkg::TAG_W-1:0]    tag_value,
  output logic                          done,
  output logic                          found,
  output logic                          overflow
);

  localparam int IDX_W  = $clog2(BUCKET_COUNT);
  localparam int FILL_W = $clog2(WAYS + 1);
  localparam int PW     = hpst_pkg::PAIR_W;
  localparam int TW     = hpst_pkg::TAG_W;
  localparam int DATA_W = WAYS * PW;
  localparam int ROW_W  = FILL_W + DATA_W;
  localparam logic [IDX_W-1:0]  LAST_IDX = IDX_W'(BUCKET_COUNT - 1);
  localparam logic [FILL_W-1:0] FULL     = FILL_W'(WAYS);

  hpst_pkg::hpst_state_t state;
  hpst_pkg::hpst_state_t state_next;

  logic                       mode_r;
  logic [hpst_pkg::KEY_W-1:0] key_r;
  logic [TW-1:0]              tag_r;
  logic [IDX_W-1:0]           bucket_r;
  logic [IDX_W-1:0]           clr_idx;
  logic [IDX_W-1:0]           clr_idx_next;

  logic                       hash_done;
  logic [IDX_W-1:0]           hash_bucket;

  logic                       ram_we;
  logic [IDX_W-1:0]           ram_waddr;
  logic [ROW_W-1:0]           ram_wdata;
  logic [ROW_W-1:0]           row;
  logic [FILL_W-1:0]          fill;
  logic [ROW_W-1:0]           row_ins;
  logic                       hit;
  logic                       done_next;
  logic                       found_next;
  logic                       overflow_next;
  logic                       accept;

  assign accept = start && !busy;

  hpst_hash #(
    .BUCKET_COUNT(BUCKET_COUNT)
  ) u_hash (
    .clk   (clk),
    .rst   (rst),
    .start (accept),
    .key   (key_id),
    .done  (hash_done),
    .bucket(hash_bucket)
  );

  hpst_ram #(
    .WIDTH(ROW_W),
    .DEPTH(BUCKET_COUNT)
  ) u_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .raddr(hash_bucket),
    .rdata(row)
  );

  always_comb begin
    fill    = row[ROW_W-1 -: FILL_W];
    hit     = 1'b0;
    row_ins = row;
    for (int w = 0; w < WAYS; w++) begin
      if ((FILL_W'(w) < fill) && (row[w*PW +: PW] == {key_r, tag_r})) begin
        hit = 1'b1;
      end
      if (fill == FILL_W'(w)) begin
        row_ins[w*PW +: PW] = {key_r, tag_r};
      end
    end
    row_ins[ROW_W-1 -: FILL_W] = fill + 1'b1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= hpst_pkg::ST_CLEAR;
      clr_idx <= '0;
      done    <= 1'b0;
    end else begin
      state   <= state_next;
      clr_idx <= clr_idx_next;
      done    <= done_next;
    end
  end

  always_ff @(posedge clk) begin
    found    <= found_next;
    overflow <= overflow_next;
    if (accept) begin
      mode_r <= mode;
      key_r  <= key_id;
      tag_r  <= tag_value;
    end
    if (hash_done) begin
      bucket_r <= hash_bucket;
    end
  end

  always_comb begin
    state_next    = state;
    clr_idx_next  = clr_idx;
    busy          = 1'b1;
    ram_we        = 1'b0;
    ram_waddr     = bucket_r;
    ram_wdata     = row_ins;
    done_next     = 1'b0;
    found_next    = 1'b0;
    overflow_next = 1'b0;
    case (state)
      hpst_pkg::ST_CLEAR: begin
        ram_we       = 1'b1;
        ram_waddr    = clr_idx;
        ram_wdata    = '0;
        clr_idx_next = clr_idx + 1'b1;
        if (clr_idx == LAST_IDX) begin
          state_next = hpst_pkg::ST_IDLE;
        end
      end
      hpst_pkg::ST_IDLE: begin
        busy = 1'b0;
        if (start) begin
          state_next = hpst_pkg::ST_HASH;
        end
      end
      hpst_pkg::ST_HASH: begin
        if (hash_done) begin
          state_next = hpst_pkg::ST_EXEC;
        end
      end
      hpst_pkg::ST_EXEC: begin
        done_next  = 1'b1;
        state_next = hpst_pkg::ST_IDLE;
        if (mode_r == hpst_pkg::MODE_LOOKUP) begin
          found_next = hit;
        end else if (fill >= FULL) begin
          overflow_next = 1'b1;
        end else begin
          ram_we = 1'b1;
        end
      end
      default: begin
        state_next = hpst_pkg::ST_IDLE;
      end
    endcase
  end

endmodule
